### sv/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif

`endif

### sv/hir_pkg.sv
package hir_pkg;

	localparam int CAP_W = 11;
	localparam int IDX_W = 64;
	localparam int PLD_W = 64;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] block_index;
		logic [PLD_W-1:0] block_payload;
	} req_item_t;

	typedef struct packed {
		logic             hit;
		logic [PLD_W-1:0] read_payload;
		logic             is_empty;
		logic [IDX_W-1:0] oldest_index;
		logic [IDX_W-1:0] newest_index;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_ADDR,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic capture;
		logic calc;
		logic addr;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic is_read;
	} sts_t;

endpackage

### sv/indexed_history_ring.sv
// Ring of the most recent measurement blocks, looked up by absolute block index. One item is
// in work at a time. After it is accepted, a push goes through CALC, which checks the held
// range and writes the ring, then LOAD, which loads the output register. A read goes through
// CALC, which checks the held range, then ADDR, which forms the ring address and reads the
// RAM, then LOAD. LOAD waits while the output register still holds a result not yet taken.
// The controller then returns to IDLE, where it takes the next item. The result sits in an
// output register, so a new item is accepted while the previous result waits. Writing
// cfg_wdata sets the capacity in use (clamped to DEPTH, zero stops storing) and empties the
// history; write it only while the block is idle. The ring RAM needs no clearing pass after
// reset.
`include "assert_macros.svh"

module indexed_history_ring #(
	parameter int DEPTH        = 1024,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  hir_pkg::req_item_t        req_data,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output hir_pkg::rsp_item_t        rsp_data,
	input  logic                      cfg_we,
	input  logic [hir_pkg::CAP_W-1:0] cfg_wdata
);
	import hir_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hir_dp #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	`ASSERT_CLK_RST(a_one_in_flight, clk, arst_n, (req_valid && req_ready) |=> !req_ready, "item accepted while another is in work")
	`ASSERT_CLK(a_cmd_onehot, clk, $onehot0({cmd.capture, cmd.calc, cmd.addr, cmd.load}), "overlapping datapath commands")
	`ASSERT_CLK_RST(a_hit_not_empty, clk, arst_n, rsp_valid |-> !(rsp_data.hit && rsp_data.is_empty), "hit reported on an empty ring")
	`ASSERT_CLK_RST(a_empty_zero, clk, arst_n, (rsp_valid && rsp_data.is_empty) |-> (rsp_data.oldest_index == '0 && rsp_data.newest_index == '0), "indices not zero on an empty ring")

endmodule

### sv/hir_ram.sv
module hir_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/hir_ctrl.sv
module hir_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  hir_pkg::sts_t sts,
	output hir_pkg::cmd_t cmd
);
	import hir_pkg::*;

	state_t state_q, state_nxt;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = ST_CALC;
				end
			end
			ST_CALC: begin
				state_nxt = sts.is_read ? ST_ADDR : ST_LOAD;
			end
			ST_ADDR: begin
				state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				if (rsp_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			ST_CALC: cmd.calc = 1'b1;
			ST_ADDR: cmd.addr = 1'b1;
			ST_LOAD: cmd.load = rsp_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// a freshly loaded beat wins over the one just taken
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

### sv/hir_dp.sv
module hir_dp #(
	parameter int DEPTH        = 1024,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  hir_pkg::req_item_t       req_data,
	output hir_pkg::rsp_item_t       rsp_data,
	input  logic                     cfg_we,
	input  logic [hir_pkg::CAP_W-1:0] cfg_wdata,
	input  hir_pkg::cmd_t            cmd,
	output hir_pkg::sts_t            sts
);
	import hir_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	req_item_t         item_q;
	logic [CAP_W-1:0]  cap_q;
	logic [CAP_W-1:0]  cap_use;
	logic [IDX_W-1:0]  count_q;
	logic [IDX_W-1:0]  oldest_q;
	logic [IDX_W-1:0]  newest_q;
	logic [CAP_W-1:0]  wslot_q;
	logic              hit_q;
	logic [CAP_W-1:0]  dist_q;
	rsp_item_t         rsp_q;

	logic              empty;
	logic              push_en;
	logic [CAP_W-1:0]  push_slot;
	logic [CAP_W:0]    push_slot_inc;
	logic              read_hit;
	logic [CAP_W-1:0]  newest_slot;
	logic [CAP_W:0]    back_slot;
	logic [CAP_W-1:0]  rd_slot;

	logic                    ram_we;
	logic                    ram_re;
	logic [PAYLOAD_BITS-1:0] ram_rdata;

	assign cap_use = (32'(cap_q) > 32'(DEPTH)) ? CAP_W'(DEPTH) : cap_q;
	assign empty   = (count_q == '0);

	assign push_en       = cmd.calc && (item_q.func == FUNC_PUSH) && (cap_use != '0);
	assign push_slot     = empty ? '0 : wslot_q;
	assign push_slot_inc = {1'b0, push_slot} + 1'b1;

	assign read_hit = (item_q.func == FUNC_READ) && !empty && (cap_use != '0) &&
		(item_q.block_index >= oldest_q) && (item_q.block_index <= newest_q);

	// newest block sits one slot behind the write slot; step back by the distance
	assign newest_slot = (wslot_q == '0) ? cap_use - 1'b1 : wslot_q - 1'b1;
	assign back_slot   = {1'b0, newest_slot} - {1'b0, dist_q};
	assign rd_slot     = back_slot[CAP_W] ? back_slot[CAP_W-1:0] + cap_use
		: back_slot[CAP_W-1:0];

	assign ram_we = push_en;
	assign ram_re = cmd.addr && hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			count_q  <= '0;
			wslot_q  <= '0;
			oldest_q <= '0;
			newest_q <= '0;
		end else if (cfg_we) begin
			cap_q   <= cfg_wdata;
			count_q <= '0;
			wslot_q <= '0;
		end else if (push_en) begin
			count_q <= count_q + 1'b1;
			wslot_q <= (push_slot_inc >= {1'b0, cap_use}) ? '0
				: push_slot_inc[CAP_W-1:0];
			if (empty) begin
				oldest_q <= item_q.block_index;
				newest_q <= item_q.block_index;
			end else begin
				newest_q <= newest_q + 1'b1;
				// ring full: drop the oldest block
				if (count_q >= IDX_W'(cap_use)) begin
					oldest_q <= oldest_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req_data;
		end
		if (cmd.calc) begin
			hit_q  <= read_hit;
			dist_q <= CAP_W'(newest_q - item_q.block_index);
		end
		if (cmd.load) begin
			rsp_q.hit          <= hit_q;
			rsp_q.read_payload <= hit_q ? PLD_W'(ram_rdata) : '0;
			rsp_q.is_empty     <= empty;
			rsp_q.oldest_index <= empty ? '0 : oldest_q;
			rsp_q.newest_index <= empty ? '0 : newest_q;
		end
	end

	hir_ram #(
		.WIDTH (PAYLOAD_BITS),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(push_slot)),
		.wdata (item_q.block_payload[PAYLOAD_BITS-1:0]),
		.re    (ram_re),
		.raddr (AW'(rd_slot)),
		.rdata (ram_rdata)
	);

	assign sts.is_read = (item_q.func == FUNC_READ);
	assign rsp_data    = rsp_q;

endmodule

### test/indexed_history_ring_tb.sv
`timescale 1ns / 100ps

module indexed_history_ring_tb;

	import hir_pkg::*;

	localparam logic [63:0] ALL_ONES = '1;
	localparam logic [CAP_W-1:0] PHASE_CAPS [8] = '{
		11'd7, 11'd2, 11'd1, 11'd16, 11'd1024, 11'd0, 11'd3, 11'd2047
	};

	typedef enum logic {ROW_CAP, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [CAP_W-1:0] cap;
		req_item_t        item;
		bit               known;
		rsp_item_t        want;
	} plan_row_t;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	req_item_t        req_data;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_item_t        rsp_data;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	// typed-in expectation travelling alongside the request beat
	bit        req_known;
	rsp_item_t req_want;

	// history model
	bit   [63:0]      hist_store [1024];
	logic [63:0]      hist_origin = '0;
	logic [63:0]      hist_pushes = '0;
	int               hist_slot   = 0;
	logic [CAP_W-1:0] hist_cap    = CAP_RESET;
	logic [63:0]      last_newest = '0;

	rsp_item_t awaited_results [$];
	plan_row_t directed_plan [$];
	int        mismatches = 0;
	bit        calm       = 1'b0;
	bit        squeeze    = 1'b0;

	indexed_history_ring dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#500000;
		$display("indexed_history_ring verification failed");
		$finish;
	end

	function automatic logic [63:0] cap_in_use();
		return (hist_cap > 11'd1024) ? 64'd1024 : 64'(hist_cap);
	endfunction

	function automatic rsp_item_t advance_history(req_item_t it);
		logic [63:0] used;
		rsp_item_t   res;
		used = cap_in_use();
		res = '0;
		if (it.func == FUNC_PUSH && used != 0) begin
			if (hist_pushes == 0) begin
				hist_origin = it.block_index;
				hist_slot = 0;
			end
			if (hist_slot >= used)
				hist_slot = 0;
			hist_store[10'(hist_slot)] = it.block_payload;
			hist_slot = (hist_slot + 1 >= used) ? 0 : hist_slot + 1;
			hist_pushes++;
		end
		res.is_empty = (hist_pushes == 0);
		if (!res.is_empty) begin
			res.newest_index = hist_origin + hist_pushes - 1;
			res.oldest_index = (hist_pushes <= used) ? hist_origin
				: hist_origin + hist_pushes - used;
		end
		// a wrapped newest below oldest never hits
		if (it.func == FUNC_READ && !res.is_empty && used != 0
				&& it.block_index >= res.oldest_index
				&& it.block_index <= res.newest_index) begin
			res.hit = 1'b1;
			res.read_payload = hist_store[10'((it.block_index - hist_origin) % used)];
		end
		last_newest = res.newest_index;
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	always @(posedge clk) begin : watch
		rsp_item_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result beat with nothing awaited");
				end else begin
					want = awaited_results.pop_front();
					compare_field("hit", rsp_data.hit, want.hit);
					compare_field("read_payload", rsp_data.read_payload, want.read_payload);
					compare_field("is_empty", rsp_data.is_empty, want.is_empty);
					compare_field("oldest_index", rsp_data.oldest_index, want.oldest_index);
					compare_field("newest_index", rsp_data.newest_index, want.newest_index);
				end
			end
			// a capacity write also drops the history
			if (cfg_we) begin
				hist_cap = cfg_wdata;
				hist_origin = '0;
				hist_pushes = '0;
				hist_slot = 0;
			end
			if (req_valid && req_ready) begin
				want = advance_history(req_data);
				awaited_results.insert(awaited_results.size(), req_known ? req_want : want);
			end
		end
	end

	initial begin
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze) begin
				squeeze = 1'b0;
				rsp_ready <= 1'b0;
				repeat (80) @(posedge clk);
			end else begin
				rsp_ready <= calm || ($urandom_range(99, 0) >= 23);
			end
		end
	end

	function automatic plan_row_t op(logic f, logic [63:0] idx, logic [63:0] pld);
		plan_row_t row;
		row.kind = ROW_ITEM;
		row.cap = '0;
		row.item.func = f;
		row.item.block_index = idx;
		row.item.block_payload = pld;
		row.known = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic plan_row_t op_known(logic f, logic [63:0] idx, logic [63:0] pld,
			logic h, logic [63:0] rp, logic e, logic [63:0] o, logic [63:0] n);
		plan_row_t row;
		row = op(f, idx, pld);
		row.known = 1'b1;
		row.want.hit = h;
		row.want.read_payload = rp;
		row.want.is_empty = e;
		row.want.oldest_index = o;
		row.want.newest_index = n;
		return row;
	endfunction

	function automatic plan_row_t cap_row(logic [CAP_W-1:0] c);
		plan_row_t row;
		row = op(FUNC_PUSH, '0, '0);
		row.kind = ROW_CAP;
		row.cap = c;
		return row;
	endfunction

	function automatic req_item_t draw_item();
		req_item_t   it;
		logic [63:0] held;
		int unsigned r;
		r = $urandom_range(99, 0);
		it.block_payload = {$urandom, $urandom};
		if (r < 50) begin
			it.func = FUNC_PUSH;
			// an origin near the top lets the indices wrap
			it.block_index = ($urandom_range(3, 0) == 0)
				? ALL_ONES - 64'($urandom_range(12, 0)) : {$urandom, $urandom};
		end else if (r < 88 && hist_pushes != 0) begin
			it.func = FUNC_READ;
			held = (hist_pushes < cap_in_use()) ? hist_pushes : cap_in_use();
			it.block_index = last_newest + 1 - 64'($urandom_range(int'(held) + 1, 0));
		end else begin
			it.func = FUNC_READ;
			it.block_index = {$urandom, $urandom};
		end
		return it;
	endfunction

	task automatic send_item(req_item_t it, bit known, rsp_item_t want);
		while (!calm && $urandom_range(99, 0) < 23) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= it;
		req_known <= known;
		req_want <= want;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cap(logic [CAP_W-1:0] c);
		drain();
		cfg_wdata <= c;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [CAP_W-1:0] cap_pick;
		int               n_items;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_data <= '0;
		req_known <= 1'b0;
		req_want <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		directed_plan = '{
			op_known(FUNC_READ, 64'd0, 64'd0, 1'b0, 64'd0, 1'b1, 64'd0, 64'd0),
			op_known(FUNC_READ, ALL_ONES, ALL_ONES, 1'b0, 64'd0, 1'b1, 64'd0, 64'd0),
			op_known(FUNC_PUSH, ALL_ONES, ALL_ONES, 1'b0, 64'd0, 1'b0, ALL_ONES, ALL_ONES),
			op_known(FUNC_READ, ALL_ONES, 64'd0, 1'b1, ALL_ONES, 1'b0, ALL_ONES, ALL_ONES),
			op_known(FUNC_PUSH, 64'd0, 64'd0, 1'b0, 64'd0, 1'b0, ALL_ONES, 64'd0),
			op_known(FUNC_READ, 64'd0, 64'd0, 1'b0, 64'd0, 1'b0, ALL_ONES, 64'd0),
			op_known(FUNC_READ, ALL_ONES, 64'd0, 1'b0, 64'd0, 1'b0, ALL_ONES, 64'd0),
			cap_row(11'd0),
			op_known(FUNC_PUSH, 64'd5, 64'h123, 1'b0, 64'd0, 1'b1, 64'd0, 64'd0),
			op_known(FUNC_READ, 64'd5, 64'd0, 1'b0, 64'd0, 1'b1, 64'd0, 64'd0),
			cap_row(11'd3),
			op(FUNC_PUSH, 64'd100, 64'h1111_1111_1111_1111),
			op(FUNC_PUSH, 64'hDEAD_BEEF_0000_0001, 64'h2222_2222_2222_2222),
			op(FUNC_PUSH, 64'd0, 64'h3333_3333_3333_3333),
			op(FUNC_PUSH, 64'd7, 64'h4444_4444_4444_4444),
			op(FUNC_PUSH, 64'd9, 64'h5555_5555_5555_5555),
			op(FUNC_READ, 64'd100, 64'd0),
			op(FUNC_READ, 64'd102, 64'd0),
			op(FUNC_READ, 64'd104, 64'd0),
			op(FUNC_READ, 64'd105, 64'd0),
			cap_row(11'd2047),
			op(FUNC_PUSH, 64'd0, 64'hAAAA_AAAA_AAAA_AAAA),
			op(FUNC_PUSH, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555),
			op(FUNC_READ, 64'd1, ALL_ONES),
			cap_row(11'd1),
			op(FUNC_PUSH, 64'h8000_0000_0000_0000, 64'h0123_4567_89AB_CDEF),
			op(FUNC_PUSH, 64'd0, 64'hFEDC_BA98_7654_3210),
			op(FUNC_READ, 64'h8000_0000_0000_0000, 64'd0),
			op(FUNC_READ, 64'h8000_0000_0000_0001, 64'd0),
			cap_row(11'd1024)
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_CAP)
				write_cap(directed_plan[i].cap);
			else
				send_item(directed_plan[i].item, directed_plan[i].known, directed_plan[i].want);
		end

		for (int phase = 0; phase < 10; phase++) begin
			if (phase < 8)
				cap_pick = PHASE_CAPS[phase];
			else if (phase == 8)
				cap_pick = CAP_W'($urandom_range(2047, 0));
			else
				cap_pick = CAP_W'($urandom_range(40, 1));
			write_cap(cap_pick);
			calm = (phase == 4);
			n_items = (cap_pick == 0) ? 20 : 70;
			for (int k = 0; k < n_items; k++) begin
				// hold the result side off so the block backs up
				if (phase == 1 && k == 5)
					squeeze = 1'b1;
				send_item(draw_item(), 1'b0, '0);
			end
		end
		calm = 1'b0;

		drain();
		if (mismatches == 0)
			$display("indexed_history_ring verification clean");
		else
			$display("indexed_history_ring verification failed");
		$finish;
	end

endmodule
